[hw/rtl/sgs_pkg.sv]
// Shared constants and types for the Savitzky-Golay smoother.
package sgs_pkg;

   // Default structural parameters of the smoother.
   localparam int DEFAULT_WINDOW      = 7;
   localparam int DEFAULT_SAMPLE_BITS = 16;

   // Fixed field widths.
   localparam int COEF_BITS      = 18;
   localparam int SHIFT_BITS     = 5;
   localparam int VALUE_BITS     = 32;
   localparam int NUM_COEFS      = 7;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic        [SHIFT_BITS-1:0] shift_type;
   typedef logic        [CSR_INDEX_BITS-1:0] csr_index_type;

   // Register map: indexes below NUM_COEFS select a tap weight.
   localparam csr_index_type CSR_COEF_LIMIT   = CSR_INDEX_BITS'(NUM_COEFS);
   localparam csr_index_type CSR_OUTPUT_SHIFT = CSR_INDEX_BITS'(NUM_COEFS);

   // Reset values of the register file: unity weight on the center tap.
   localparam int        CENTER_TAP   = 3;
   localparam coef_type  UNITY_COEF   = COEF_BITS'(65536);
   localparam shift_type SHIFT_RESET  = SHIFT_BITS'(16);

endpackage

[hw/rtl/sgs_if.sv]
// Channel interfaces of the Savitzky-Golay smoother: samples, results and register writes.

interface sgs_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface sgs_rsp_if import sgs_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         primed;

   modport source (output valid, output value, output primed, input ready);
   modport sink   (input valid, input value, input primed, output ready);
endinterface

interface sgs_csr_if import sgs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/savitzky_golay_smoother.sv]
// Savitzky-Golay smoother / differentiator: sliding window dot product with loadable weights.
//
// Usage:
//   req_chan carries one signed sample per beat. rsp_chan returns one beat per sample:
//   value is the weighted window sum, rounded, shifted right by output_shift and
//   saturated to signed 32 bits; primed is set once WINDOW samples have been taken.
//   csr_chan writes the tap weights (index 0..6, oldest tap first) and the output
//   shift (index 7); it is always ready and should only be used while the block is idle.
// Pipeline:
//   Throughput is one sample per clock while rsp_chan is not stalling; the stages are a
//   window register, one multiplier per tap, an adder tree, a rounding adder and a
//   shift/saturate stage, through which each accepted sample passes in that order.
// Reset:
//   Synchronous reset empties the pipeline, clears the sample count and loads the
//   default weights (unity center tap, shift of 16). The first sample after reset
//   fills every window tap.
// Back pressure:
//   Each stage holds its beat while the next one is full, so bubbles are squeezed
//   out and samples keep being taken until all five stages hold a beat.
module savitzky_golay_smoother import sgs_pkg::*; #(
   parameter int WINDOW      = DEFAULT_WINDOW,
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input logic        clock,
   input logic        reset,
   sgs_req_if.sink    req_chan,
   sgs_rsp_if.source  rsp_chan,
   sgs_csr_if.sink    csr_chan
);

   localparam int SEEN_BITS = $clog2(WINDOW + 1);
   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int TREE_BITS = PROD_BITS + $clog2(WINDOW) + 1;
   localparam int SUM_BITS  = (TREE_BITS > VALUE_BITS + 1) ? TREE_BITS : VALUE_BITS + 1;
   localparam logic [SEEN_BITS-1:0] SEEN_FULL = SEEN_BITS'(WINDOW);

   // Register file.
   coef_type  coef_ff [NUM_COEFS];
   shift_type shift_ff;

   // Stage 1: window and sample count.
   logic signed [SAMPLE_BITS-1:0] window_ff [WINDOW];
   logic [SEEN_BITS-1:0]          seen_ff;
   logic                          v1_ff;

   // Stage 2: products.
   logic signed [PROD_BITS-1:0] prod_ff [WINDOW];
   logic                        primed2_ff;
   logic                        v2_ff;

   // Stage 3: sum.
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic                       primed3_ff;
   logic                       v3_ff;

   // Stage 4: rounded sum.
   logic [SUM_BITS-1:0]        half_in;
   logic signed [SUM_BITS-1:0] round_ff;
   logic                       primed4_ff;
   logic                       v4_ff;

   // Output register.
   logic signed [SUM_BITS-1:0]   shifted_in;
   logic                         pos_ovf;
   logic                         neg_ovf;
   logic signed [VALUE_BITS-1:0] value_in;
   logic signed [VALUE_BITS-1:0] value_ff;
   logic                         primed_ff;
   logic                         rsp_valid_ff;

   // Handshake chain.
   logic out_free;
   logic free1, free2, free3, free4;
   logic adv1, adv2, adv3, adv4;
   logic accept;

   // Each stage may load when it is empty or its beat moves on.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign free4    = !v4_ff || out_free;
   assign free3    = !v3_ff || free4;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;
   assign adv4     = v4_ff && out_free;
   assign adv3     = v3_ff && free4;
   assign adv2     = v2_ff && free3;
   assign adv1     = v1_ff && free2;
   assign accept   = req_chan.valid && free1;

   assign req_chan.ready = free1;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = value_ff;
   assign rsp_chan.primed = primed_ff;

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[CENTER_TAP] <= UNITY_COEF;
         shift_ff            <= SHIFT_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index < CSR_COEF_LIMIT) begin
            coef_ff[csr_chan.index[$clog2(NUM_COEFS)-1:0]] <= csr_chan.data[COEF_BITS-1:0];
         end else if (csr_chan.index == CSR_OUTPUT_SHIFT) begin
            shift_ff <= csr_chan.data[SHIFT_BITS-1:0];
         end
      end
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept || (v1_ff && !free2);
         v2_ff        <= adv1 || (v2_ff && !free3);
         v3_ff        <= adv2 || (v3_ff && !free4);
         v4_ff        <= adv3 || (v4_ff && !out_free);
         rsp_valid_ff <= adv4 || (rsp_valid_ff && !rsp_chan.ready);
      end
   end

   // Sample count; zero means the next sample fills the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (accept && seen_ff != SEEN_FULL) begin
         seen_ff <= seen_ff + 1'b1;
      end
   end

   // Window shift, or fill on the first sample.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (seen_ff == '0) begin
            for (int i = 0; i < WINDOW; i++) begin
               window_ff[i] <= req_chan.sample;
            end
         end else begin
            for (int i = 0; i < WINDOW - 1; i++) begin
               window_ff[i] <= window_ff[i + 1];
            end
            window_ff[WINDOW-1] <= req_chan.sample;
         end
      end
   end

   // One multiplier per tap.
   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int i = 0; i < WINDOW; i++) begin
            prod_ff[i] <= PROD_BITS'(coef_ff[i] * window_ff[i]);
         end
         primed2_ff <= (seen_ff == SEEN_FULL);
      end
   end

   // Adder tree over the products.
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < WINDOW; i++) begin
         sum_in = sum_in + SUM_BITS'(prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         sum_ff     <= sum_in;
         primed3_ff <= primed2_ff;
      end
   end

   // Add half of the last kept unit; a zero shift adds nothing.
   assign half_in = (SUM_BITS'(1) << shift_ff) >> 1;

   always_ff @(posedge clock) begin
      if (adv3) begin
         round_ff   <= sum_ff + $signed(half_in);
         primed4_ff <= primed3_ff;
      end
   end

   // Arithmetic shift and saturation to 32 bits.
   assign shifted_in = round_ff >>> shift_ff;
   assign pos_ovf = !shifted_in[SUM_BITS-1] && (|shifted_in[SUM_BITS-2:VALUE_BITS-1]);
   assign neg_ovf = shifted_in[SUM_BITS-1] && !(&shifted_in[SUM_BITS-2:VALUE_BITS-1]);

   always_comb begin
      if (pos_ovf) begin
         value_in = {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else if (neg_ovf) begin
         value_in = {1'b1, {(VALUE_BITS-1){1'b0}}};
      end else begin
         value_in = shifted_in[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         value_ff  <= value_in;
         primed_ff <= primed4_ff;
      end
   end

   // The first sample after reset lands in every tap.
   property p_first_fill;
      @(posedge clock) disable iff (reset)
         (accept && seen_ff == '0) |=> (window_ff[0] == window_ff[WINDOW-1]);
   endproperty
   a_first_fill: assert property (p_first_fill) else $error("window not filled by first sample");

   // The sample count saturates at the window length.
   property p_seen_bound;
      @(posedge clock) disable iff (reset) seen_ff <= SEEN_FULL;
   endproperty
   a_seen_bound: assert property (p_seen_bound) else $error("sample count overran");

   // A primed result can only follow a full window count.
   property p_primed_count;
      @(posedge clock) disable iff (reset) (rsp_valid_ff && primed_ff) |-> (seen_ff == SEEN_FULL);
   endproperty
   a_primed_count: assert property (p_primed_count) else $error("primed without full window");

   // An accepted sample always occupies the first stage.
   property p_accept_lands;
      @(posedge clock) disable iff (reset) accept |=> v1_ff;
   endproperty
   a_accept_lands: assert property (p_accept_lands) else $error("accepted sample lost");

   // A new result only appears when the last stage held a beat.
   property p_result_source;
      @(posedge clock) disable iff (reset) $rose(rsp_valid_ff) |-> $past(v4_ff);
   endproperty
   a_result_source: assert property (p_result_source) else $error("result without source beat");

endmodule
